// ----- src/bdu_pkg.sv -----
// Shared types, constants and calendar helpers for the BCD date/time to seconds converter.
package bdu_pkg;

    localparam logic [31:0] EPOCH_RESET = 32'd946681200;
    localparam int unsigned PADDR_W     = 3;
    localparam logic        REG_EPOCH_BASE = 1'b0;
    localparam logic [34:0] DAY_SECS    = 35'd86400;

    typedef struct packed {
        logic [11:0]        full_year;
        logic [6:0]         month;
        logic [7:0]         day;
        logic [5:0]         hour;
        logic [7:0]         minute;
        logic [7:0]         second;
        logic [2:0]         weekday;
        logic               over;
        logic signed [17:0] day_count;
        logic [17:0]        tod_secs;
    } t_dec;

    function automatic logic [7:0] bcd_val(input logic [3:0] tens, input logic [3:0] units);
        logic [7:0] t;
        t = {4'b0, tens};
        return (t << 3) + (t << 1) + {4'b0, units};
    endfunction

    // Whole days before the first of the given month; code 13 stands for a full year.
    function automatic logic [8:0] days_before_month(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            4'd13:   d = 9'd365;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ----- src/bdu_apb_regs.sv -----
// APB register block holding the epoch base.
module bdu_apb_regs
    import bdu_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [31:0]        i_pwdata,
    output logic [31:0]        o_prdata,
    output logic               o_pready,
    output logic [31:0]        o_epoch_base
);

    logic [31:0] r_epoch_base;
    logic        w_hit;

    assign w_hit = i_paddr[PADDR_W-1] == REG_EPOCH_BASE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch_base <= EPOCH_RESET;
        end else if (i_psel && i_penable && i_pwrite && w_hit) begin
            r_epoch_base <= i_pwdata;
        end
    end

    assign o_prdata     = w_hit ? r_epoch_base : 32'd0;
    assign o_pready     = 1'b1;
    assign o_epoch_base = r_epoch_base;

endmodule

// ----- src/bdu_decode.sv -----
// First stage: BCD field decode, day count and time-of-day seconds, registered.
module bdu_decode
    import bdu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_seconds_byte,
    input  logic [7:0] i_minutes_byte,
    input  logic [7:0] i_hours_byte,
    input  logic [7:0] i_weekday_byte,
    input  logic [7:0] i_date_byte,
    input  logic [7:0] i_month_century_byte,
    input  logic [7:0] i_year_byte,
    output logic       o_valid,
    output t_dec       o_dec
);

    logic        r_valid;
    t_dec        r_dec;
    t_dec        n_dec;
    logic [8:0]  w_yoff;
    logic [7:0]  w_hour12;
    logic [7:0]  w_hour24;
    logic [7:0]  w_hour;
    logic [3:0]  w_meff;
    logic        w_leap;
    logic [16:0] w_ydays;
    logic [8:0]  w_mdays;

    always_comb begin
        w_yoff = {1'b0, bcd_val(i_year_byte[7:4], i_year_byte[3:0])}
               + (i_month_century_byte[7] ? 9'd100 : 9'd0);
        n_dec.full_year = 12'd2000 + {3'b0, w_yoff};
        n_dec.month     = 7'(bcd_val({1'b0, i_month_century_byte[6:4]},
                                     i_month_century_byte[3:0]));
        n_dec.day       = bcd_val(i_date_byte[7:4], i_date_byte[3:0]);
        n_dec.minute    = bcd_val(i_minutes_byte[7:4], i_minutes_byte[3:0]);
        n_dec.second    = bcd_val(i_seconds_byte[7:4], i_seconds_byte[3:0]);
        n_dec.weekday   = i_weekday_byte[2:0];

        // Bit 6 selects 12-hour mode, where bit 5 is the PM flag.
        w_hour12 = bcd_val({3'b0, i_hours_byte[4]}, i_hours_byte[3:0])
                 + (i_hours_byte[5] ? 8'd12 : 8'd0);
        w_hour24 = bcd_val({2'b0, i_hours_byte[5:4]}, i_hours_byte[3:0]);
        w_hour   = i_hours_byte[6] ? w_hour12 : w_hour24;
        n_dec.hour = w_hour[5:0];

        n_dec.over = n_dec.month > 7'd12;
        w_meff     = n_dec.over ? 4'd13 : n_dec.month[3:0];
        // 2000 is a multiple of four, so the offset alone decides leap years.
        w_leap     = w_yoff[1:0] == 2'b00;
        w_mdays    = days_before_month(w_meff)
                   + {8'b0, (w_meff > 4'd2) && w_leap};
        w_ydays    = {8'b0, w_yoff} * 17'd365 + (({8'b0, w_yoff} + 17'd3) >> 2);

        n_dec.day_count = 18'({1'b0, w_ydays} + {9'b0, w_mdays}
                              + {10'b0, n_dec.day} - 18'd1);
        n_dec.tod_secs  = {10'b0, n_dec.second}
                        + {10'b0, n_dec.minute} * 18'd60
                        + {12'b0, n_dec.hour} * 18'd3600;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dec <= n_dec;
    end

    assign o_valid = r_valid;
    assign o_dec   = r_dec;

endmodule

// ----- src/bdu_accum.sv -----
// Second stage: day count in seconds plus time-of-day seconds and epoch base, registered.
module bdu_accum
    import bdu_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_dec               i_dec,
    input  logic [31:0]        i_epoch_base,
    output logic               o_valid,
    output logic [11:0]        o_full_year,
    output logic [6:0]         o_month_number,
    output logic [7:0]         o_day_of_month,
    output logic [5:0]         o_hour_number,
    output logic [7:0]         o_minute_number,
    output logic [7:0]         o_second_number,
    output logic [2:0]         o_weekday_number,
    output logic signed [34:0] o_seconds_since_epoch,
    output logic               o_month_out_of_range
);

    logic        r_valid;
    t_dec        r_dec;
    logic [34:0] r_total;
    logic [34:0] n_total;

    // Two's complement sums taken modulo 2^35 give the signed count directly.
    always_comb begin
        n_total = {3'b0, i_epoch_base}
                + {17'b0, i_dec.tod_secs}
                + {{17{i_dec.day_count[17]}}, i_dec.day_count} * DAY_SECS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dec   <= i_dec;
        r_total <= n_total;
    end

    assign o_valid               = r_valid;
    assign o_full_year           = r_dec.full_year;
    assign o_month_number        = r_dec.month;
    assign o_day_of_month        = r_dec.day;
    assign o_hour_number         = r_dec.hour;
    assign o_minute_number       = r_dec.minute;
    assign o_second_number       = r_dec.second;
    assign o_weekday_number      = r_dec.weekday;
    assign o_seconds_since_epoch = $signed(r_total);
    assign o_month_out_of_range  = r_dec.over;

    a_over_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_dec.over == (r_dec.month > 7'd12)))
        else $error("month range flag disagrees with decoded month");

endmodule

// ----- src/bcd_datetime_to_unix_seconds_top.sv -----
// Top level of the BCD date/time to seconds converter.
//
//   Channel   Handshake                  Payload
//   input     start & !busy              i_*_byte (seven BCD registers)
//   result    o_result_valid (strobe)    o_* decoded fields and seconds count
//   config    psel & penable & pwrite    pwdata at paddr (epoch base at 0)
//
// An accepted transaction gives its result strobe once it has passed the registers below;
// one transaction can be accepted at every edge, busy is always low.
// The latency is set by the input register, the decode stage and the result register.
// Reset is synchronous and active low; it clears the pipeline and restores the epoch base.
// The receiver cannot stall; each result is presented for exactly one cycle.
module bcd_datetime_to_unix_seconds_top
    import bdu_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [7:0]         i_seconds_byte,
    input  logic [7:0]         i_minutes_byte,
    input  logic [7:0]         i_hours_byte,
    input  logic [7:0]         i_weekday_byte,
    input  logic [7:0]         i_date_byte,
    input  logic [7:0]         i_month_century_byte,
    input  logic [7:0]         i_year_byte,
    output logic               o_result_valid,
    output logic [11:0]        o_full_year,
    output logic [6:0]         o_month_number,
    output logic [7:0]         o_day_of_month,
    output logic [5:0]         o_hour_number,
    output logic [7:0]         o_minute_number,
    output logic [7:0]         o_second_number,
    output logic [2:0]         o_weekday_number,
    output logic signed [34:0] o_seconds_since_epoch,
    output logic               o_month_out_of_range,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic        r_in_valid;
    logic [7:0]  r_seconds_byte;
    logic [7:0]  r_minutes_byte;
    logic [7:0]  r_hours_byte;
    logic [7:0]  r_weekday_byte;
    logic [7:0]  r_date_byte;
    logic [7:0]  r_month_century_byte;
    logic [7:0]  r_year_byte;
    logic        w_accept;
    logic        w_dec_valid;
    t_dec        w_dec;
    logic [31:0] w_epoch_base;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_seconds_byte       <= i_seconds_byte;
            r_minutes_byte       <= i_minutes_byte;
            r_hours_byte         <= i_hours_byte;
            r_weekday_byte       <= i_weekday_byte;
            r_date_byte          <= i_date_byte;
            r_month_century_byte <= i_month_century_byte;
            r_year_byte          <= i_year_byte;
        end
    end

    bdu_apb_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_prdata     (prdata),
        .o_pready     (pready),
        .o_epoch_base (w_epoch_base)
    );

    bdu_decode u_decode (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (r_in_valid),
        .i_seconds_byte       (r_seconds_byte),
        .i_minutes_byte       (r_minutes_byte),
        .i_hours_byte         (r_hours_byte),
        .i_weekday_byte       (r_weekday_byte),
        .i_date_byte          (r_date_byte),
        .i_month_century_byte (r_month_century_byte),
        .i_year_byte          (r_year_byte),
        .o_valid              (w_dec_valid),
        .o_dec                (w_dec)
    );

    bdu_accum u_accum (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (w_dec_valid),
        .i_dec                 (w_dec),
        .i_epoch_base          (w_epoch_base),
        .o_valid               (o_result_valid),
        .o_full_year           (o_full_year),
        .o_month_number        (o_month_number),
        .o_day_of_month        (o_day_of_month),
        .o_hour_number         (o_hour_number),
        .o_minute_number       (o_minute_number),
        .o_second_number       (o_second_number),
        .o_weekday_number      (o_weekday_number),
        .o_seconds_since_epoch (o_seconds_since_epoch),
        .o_month_out_of_range  (o_month_out_of_range)
    );

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##3 o_result_valid)
        else $error("accepted transaction did not produce a result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(w_accept, 3))
        else $error("result strobe without an accepted transaction");

    // Non-BCD year digits can reach 165, so with the century bit the year tops out at 2265.
    a_year_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_full_year >= 12'd2000 && o_full_year <= 12'd2265))
        else $error("decoded year outside the representable span");

endmodule

// ----- bench/tb_bcd_datetime_to_unix_seconds_top.sv -----
// Self-checking testbench for the BCD calendar snapshot to seconds converter.
module tb_bcd_datetime_to_unix_seconds_top
    import bdu_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_PER_EPOCH = 80;
    localparam logic [PADDR_W-1:0] EPOCH_ADDR = PADDR_W'(4 * REG_EPOCH_BASE);
    localparam int HOUR_12H_BIT = 6;
    localparam int HOUR_PM_BIT = 5;
    localparam int CENTURY_BIT = 7;
    localparam longint SECS_PER_DAY = 86400;
    localparam int DAYS_BEFORE[14] = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                                      304, 334, 365};

    typedef struct packed {
        logic [7:0] seconds;
        logic [7:0] minutes;
        logic [7:0] hours;
        logic [7:0] weekday;
        logic [7:0] date;
        logic [7:0] month_century;
        logic [7:0] year;
    } t_rtc_snapshot;

    typedef struct packed {
        logic [11:0]        year;
        logic [6:0]         month;
        logic [7:0]         day;
        logic [5:0]         hour;
        logic [7:0]         minute;
        logic [7:0]         second;
        logic [2:0]         weekday;
        logic signed [34:0] count;
        logic               month_over;
    } t_calendar_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [7:0]         i_seconds_byte = '0;
    logic [7:0]         i_minutes_byte = '0;
    logic [7:0]         i_hours_byte = '0;
    logic [7:0]         i_weekday_byte = '0;
    logic [7:0]         i_date_byte = '0;
    logic [7:0]         i_month_century_byte = '0;
    logic [7:0]         i_year_byte = '0;
    logic               o_result_valid;
    logic [11:0]        o_full_year;
    logic [6:0]         o_month_number;
    logic [7:0]         o_day_of_month;
    logic [5:0]         o_hour_number;
    logic [7:0]         o_minute_number;
    logic [7:0]         o_second_number;
    logic [2:0]         o_weekday_number;
    logic signed [34:0] o_seconds_since_epoch;
    logic               o_month_out_of_range;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    logic [31:0]        epoch_base_copy = EPOCH_RESET;
    t_calendar_result   pending_results[$];
    int                 error_count = 0;
    int                 items_sent = 0;
    int                 results_checked = 0;
    int                 epoch_writes = 0;
    int                 cycle_count = 0;
    bit                 no_idle = 1'b0;

    bcd_datetime_to_unix_seconds_top dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .start                (start),
        .busy                 (busy),
        .i_seconds_byte       (i_seconds_byte),
        .i_minutes_byte       (i_minutes_byte),
        .i_hours_byte         (i_hours_byte),
        .i_weekday_byte       (i_weekday_byte),
        .i_date_byte          (i_date_byte),
        .i_month_century_byte (i_month_century_byte),
        .i_year_byte          (i_year_byte),
        .o_result_valid       (o_result_valid),
        .o_full_year          (o_full_year),
        .o_month_number       (o_month_number),
        .o_day_of_month       (o_day_of_month),
        .o_hour_number        (o_hour_number),
        .o_minute_number      (o_minute_number),
        .o_second_number      (o_second_number),
        .o_weekday_number     (o_weekday_number),
        .o_seconds_since_epoch(o_seconds_since_epoch),
        .o_month_out_of_range (o_month_out_of_range),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles.", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [7:0] to_bcd(input int unsigned v);
        return 8'(((v / 10) << 4) | (v % 10));
    endfunction

    function automatic t_calendar_result convert_snapshot(input t_rtc_snapshot s,
                                                         input logic [31:0] base);
        int unsigned      year_off;
        int unsigned      month_v;
        int unsigned      date_v;
        int unsigned      hour_v;
        int unsigned      sec_v;
        int unsigned      min_v;
        int unsigned      month_idx;
        longint           month_days;
        longint           year_days;
        longint           base_l;
        longint           total;
        bit               leap;
        t_calendar_result r;
        year_off = (s.month_century[CENTURY_BIT] ? 100 : 0) + s.year[7:4] * 10 + s.year[3:0];
        month_v = s.month_century[6:4] * 10 + s.month_century[3:0];
        date_v = s.date[7:4] * 10 + s.date[3:0];
        sec_v = s.seconds[7:4] * 10 + s.seconds[3:0];
        min_v = s.minutes[7:4] * 10 + s.minutes[3:0];
        if (s.hours[HOUR_12H_BIT]) begin
            hour_v = s.hours[4] * 10 + s.hours[3:0] + (s.hours[HOUR_PM_BIT] ? 12 : 0);
        end else begin
            hour_v = s.hours[5:4] * 10 + s.hours[3:0];
        end
        leap = ((2000 + year_off) % 4) == 0;
        month_idx = (month_v > 12) ? 13 : month_v;
        month_days = DAYS_BEFORE[month_idx];
        if (month_idx > 2 && leap) begin
            month_days++;
        end
        // Every year offset divisible by four before this one contributed a leap day.
        year_days = longint'(year_off) * 365 + (year_off + 3) / 4;
        base_l = base;
        total = base_l + sec_v + longint'(min_v) * 60 + longint'(hour_v) * 3600
              + (longint'(date_v) - 1) * SECS_PER_DAY + (month_days + year_days) * SECS_PER_DAY;
        r.year = 12'(2000 + year_off);
        r.month = 7'(month_v);
        r.day = 8'(date_v);
        r.hour = 6'(hour_v);
        r.minute = 8'(min_v);
        r.second = 8'(sec_v);
        r.weekday = s.weekday[2:0];
        r.count = total[34:0];
        r.month_over = month_v > 12;
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 55) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 30);
    endfunction

    function automatic t_rtc_snapshot random_timestamp();
        t_rtc_snapshot s;
        s.seconds = to_bcd($urandom_range(0, 59));
        s.minutes = to_bcd($urandom_range(0, 59));
        if ($urandom_range(0, 1)) begin
            s.hours = to_bcd($urandom_range(1, 12));
            s.hours[HOUR_12H_BIT] = 1'b1;
            s.hours[HOUR_PM_BIT] = 1'($urandom_range(0, 1));
        end else begin
            s.hours = to_bcd($urandom_range(0, 23));
        end
        s.weekday = 8'($urandom_range(1, 7));
        s.date = to_bcd($urandom_range(1, 31));
        s.month_century = to_bcd($urandom_range(1, 12));
        s.month_century[CENTURY_BIT] = 1'($urandom_range(0, 1));
        s.year = to_bcd($urandom_range(0, 99));
        return s;
    endfunction

    function automatic t_rtc_snapshot random_snapshot();
        t_rtc_snapshot s;
        int            roll;
        roll = $urandom_range(0, 99);
        s = random_timestamp();
        if (roll >= 90) begin
            s = t_rtc_snapshot'(56'({$urandom, $urandom}));
        end else if (roll >= 75) begin
            // Corrupt one register of an otherwise sane timestamp.
            case ($urandom_range(0, 6))
                0: s.seconds = 8'($urandom);
                1: s.minutes = 8'($urandom);
                2: s.hours = 8'($urandom);
                3: s.weekday = 8'($urandom);
                4: s.date = 8'($urandom);
                5: s.month_century = 8'($urandom);
                default: s.year = 8'($urandom);
            endcase
        end
        return s;
    endfunction

    // Presents one snapshot and holds it until the block accepts the transaction.
    task automatic send_snapshot(input t_rtc_snapshot s);
        int gap;
        @(negedge i_clk);
        start <= 1'b1;
        i_seconds_byte <= s.seconds;
        i_minutes_byte <= s.minutes;
        i_hours_byte <= s.hours;
        i_weekday_byte <= s.weekday;
        i_date_byte <= s.date;
        i_month_century_byte <= s.month_century;
        i_year_byte <= s.year;
        do begin
            @(posedge i_clk);
        end while (busy);
        pending_results.push_back(convert_snapshot(s, epoch_base_copy));
        items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Writes the epoch base once the pipeline has drained, then reads it back.
    task automatic write_epoch_base(input logic [31:0] value);
        // Stop issuing transactions before waiting for the pipeline to empty.
        @(negedge i_clk);
        start <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        start <= 1'b0;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= EPOCH_ADDR;
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        epoch_base_copy = value;
        epoch_writes++;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        if (prdata !== value) begin
            $error("epoch_base readback: expected %h, actual %h", value, prdata);
            error_count++;
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_field(input string name, input longint expected, input longint actual);
        if (expected !== actual) begin
            $error("%s: expected %0d, actual %0d", name, expected, actual);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_calendar_result want;
        if (i_rst_n && o_result_valid) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with no snapshot outstanding");
                error_count++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                check_field("full_year", want.year, o_full_year);
                check_field("month_number", want.month, o_month_number);
                check_field("day_of_month", want.day, o_day_of_month);
                check_field("hour_number", want.hour, o_hour_number);
                check_field("minute_number", want.minute, o_minute_number);
                check_field("second_number", want.second, o_second_number);
                check_field("weekday_number", want.weekday, o_weekday_number);
                check_field("seconds_since_epoch", want.count, o_seconds_since_epoch);
                check_field("month_out_of_range", want.month_over, o_month_out_of_range);
            end
        end
    end

    task automatic test_calendar_edges();
        no_idle = 1'b1;
        send_snapshot('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        send_snapshot('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        send_snapshot('{8'h00, 8'h00, 8'h00, 8'h06, 8'h01, 8'h01, 8'h00});
        send_snapshot('{8'h59, 8'h59, 8'h23, 8'h07, 8'h31, 8'h12, 8'h99});
        // Leap-day boundary, then the first year of the next century with no exception.
        send_snapshot('{8'h30, 8'h15, 8'h10, 8'h04, 8'h29, 8'h02, 8'h24});
        send_snapshot('{8'h00, 8'h00, 8'h00, 8'h05, 8'h01, 8'h03, 8'h24});
        send_snapshot('{8'h00, 8'h00, 8'h00, 8'h05, 8'h01, 8'h83, 8'h00});
        send_snapshot('{8'h45, 8'h30, 8'h12, 8'h02, 8'h15, 8'h08, 8'h23});
        no_idle = 1'b0;
    endtask

    task automatic test_special_cases();
        // 12-hour mode at midnight and noon codes, AM and PM.
        send_snapshot('{8'h00, 8'h00, 8'h52, 8'h01, 8'h10, 8'h06, 8'h21});
        send_snapshot('{8'h00, 8'h00, 8'h72, 8'h01, 8'h10, 8'h06, 8'h21});
        send_snapshot('{8'h59, 8'h01, 8'h7F, 8'h03, 8'h10, 8'h06, 8'h21});
        // Non-BCD digits everywhere, month thirteen, month zero and month one.
        send_snapshot('{8'hAF, 8'hFA, 8'h3F, 8'hF8, 8'hAA, 8'h1F, 8'hBC});
        send_snapshot('{8'h00, 8'h00, 8'h00, 8'h00, 8'h15, 8'h13, 8'h20});
        send_snapshot('{8'h00, 8'h00, 8'h00, 8'h00, 8'h15, 8'h80, 8'h20});
        send_snapshot('{8'h00, 8'h00, 8'h00, 8'h00, 8'h15, 8'h01, 8'h20});
        // Date zero pulls the count one day below the start of the month.
        send_snapshot('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00});
    endtask

    task automatic test_epoch_extremes();
        write_epoch_base(32'h0000_0000);
        send_snapshot('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00});
        send_snapshot('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        write_epoch_base(32'hFFFF_FFFF);
        send_snapshot('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        send_snapshot('{8'h59, 8'h59, 8'h23, 8'h07, 8'h31, 8'hFF, 8'h99});
    endtask

    task automatic test_random_snapshots();
        logic [31:0] epochs[5];
        epochs = '{EPOCH_RESET, 32'h0000_0000, 32'hFFFF_FFFF, $urandom, EPOCH_RESET};
        foreach (epochs[e]) begin
            write_epoch_base(epochs[e]);
            for (int n = 0; n < RANDOM_PER_EPOCH; n++) begin
                // Every so often switch to a back-to-back burst.
                if (n % 20 == 0) begin
                    no_idle = ($urandom_range(0, 3) == 0);
                end
                send_snapshot(random_snapshot());
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_calendar_edges();
        test_special_cases();
        test_epoch_extremes();
        test_random_snapshots();
        @(negedge i_clk);
        start <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Converted %0d snapshots and checked %0d results across %0d epoch base writes.",
                 items_sent, results_checked, epoch_writes);
        $display("Covered 12/24-hour decode, non-BCD digits, month and date extremes, leap years.");
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
